// File: rtl/pga_pkg.sv
package pga_pkg;

    // Formats: signed positions and accelerations, unsigned mass
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Magnitude of a coordinate difference
    localparam int DW   = COORD_WIDTH + 1;
    // Squared length, its square and its cube
    localparam int L2W  = 2 * DW;
    localparam int LQW  = 2 * L2W;
    localparam int L3W  = 3 * L2W;
    // Mass times difference magnitude, and its square
    localparam int MDW  = 2 * COORD_WIDTH;
    localparam int M2W  = 2 * MDW;
    // Squared numerator including the fraction scale
    localparam int NW   = M2W + 4 * FRAC_BITS;
    // Trial term of one quotient bit
    localparam int TW_A = NW + COORD_WIDTH + 1;
    localparam int TW_B = L3W + 2 * COORD_WIDTH;
    localparam int TW   = (TW_A > TW_B) ? TW_A : TW_B;

    // Pipeline layout: front stages, the bit stages, one output stage
    localparam int BIT0 = 6;
    localparam int NS   = BIT0 + COORD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

endpackage

// File: rtl/pairwise_gravity_accel.sv
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_target_xyz, i_source_xyz, i_source_mass
// output    o_valid / i_ready    o_accel_xyz, o_saturated, o_coincident
//
// One item per cycle while i_ready does not stall the output; the quotient search
// takes one stage per quotient bit.
// Reset (i_rst_n low at a clock edge) empties every stage; payload is not cleared.
// Each stage holds its item while the stage after it is full and stalled,
// so bubbles close up and an item is taken while a result waits.
module pairwise_gravity_accel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pga_pkg::t_coord                   i_target_x,
    input  pga_pkg::t_coord                   i_target_y,
    input  pga_pkg::t_coord                   i_target_z,
    input  pga_pkg::t_coord                   i_source_x,
    input  pga_pkg::t_coord                   i_source_y,
    input  pga_pkg::t_coord                   i_source_z,
    input  logic [pga_pkg::COORD_WIDTH-1:0]   i_source_mass,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pga_pkg::t_coord                   o_accel_x,
    output pga_pkg::t_coord                   o_accel_y,
    output pga_pkg::t_coord                   o_accel_z,
    output logic                              o_saturated,
    output logic                              o_coincident
);
    import pga_pkg::*;

    localparam int W = COORD_WIDTH;

    // Stage occupancy and advance chain
    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: difference vector, split into magnitude and sign
    logic [DW-1:0] d [3];
    logic [DW-1:0] r0_mag [3];
    logic          r0_neg [3];
    logic [W-1:0]  r0_mass;

    always_comb begin
        d[0] = {i_source_x[W-1], i_source_x} - {i_target_x[W-1], i_target_x};
        d[1] = {i_source_y[W-1], i_source_y} - {i_target_y[W-1], i_target_y};
        d[2] = {i_source_z[W-1], i_source_z} - {i_target_z[W-1], i_target_z};
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int k = 0; k < 3; k++) begin
                r0_neg[k] <= d[k][DW-1];
                r0_mag[k] <= d[k][DW-1] ? (~d[k] + 1'b1) : d[k];
            end
            r0_mass <= i_source_mass;
        end
    end

    // Stage 1: squares and mass products
    logic [W+DW-1:0] mprod [3];
    logic [L2W-1:0]  r1_sq  [3];
    logic [MDW-1:0]  r1_mdk [3];
    logic            r1_neg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mprod[k] = r0_mass * r0_mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_sq[k]  <= r0_mag[k] * r0_mag[k];
                r1_mdk[k] <= mprod[k][MDW-1:0];
                r1_neg[k] <= r0_neg[k];
            end
        end
    end

    // Stage 2: squared length
    logic [L2W-1:0] r2_l2;
    logic [MDW-1:0] r2_mdk [3];
    logic           r2_neg [3];

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_l2 <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            for (int k = 0; k < 3; k++) begin
                r2_mdk[k] <= r1_mdk[k];
                r2_neg[k] <= r1_neg[k];
            end
        end
    end

    // Stage 3: partial products of l2^2 and of each squared numerator
    logic [2*DW-1:0] r3_ll, r3_lh, r3_hh;
    logic [L2W-1:0]  r3_l2;
    logic            r3_zero;
    logic [MDW-1:0]  r3_maa [3];
    logic [MDW-1:0]  r3_mab [3];
    logic [MDW-1:0]  r3_mbb [3];
    logic            r3_neg [3];

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_ll   <= r2_l2[DW-1:0] * r2_l2[DW-1:0];
            r3_lh   <= r2_l2[DW-1:0] * r2_l2[L2W-1:DW];
            r3_hh   <= r2_l2[L2W-1:DW] * r2_l2[L2W-1:DW];
            r3_l2   <= r2_l2;
            r3_zero <= (r2_l2 == '0);
            for (int k = 0; k < 3; k++) begin
                r3_maa[k] <= r2_mdk[k][W-1:0] * r2_mdk[k][W-1:0];
                r3_mab[k] <= r2_mdk[k][W-1:0] * r2_mdk[k][MDW-1:W];
                r3_mbb[k] <= r2_mdk[k][MDW-1:W] * r2_mdk[k][MDW-1:W];
                r3_neg[k] <= r2_neg[k];
            end
        end
    end

    // Stage 4: sum the partial products
    logic [LQW-1:0] r4_l2sq;
    logic [L2W-1:0] r4_l2;
    logic           r4_zero;
    logic [M2W-1:0] r4_m2  [3];
    logic           r4_neg [3];

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_l2sq <= {r3_hh, r3_ll} + {{(DW-1){1'b0}}, r3_lh, {(DW+1){1'b0}}};
            r4_l2   <= r3_l2;
            r4_zero <= r3_zero;
            for (int k = 0; k < 3; k++) begin
                r4_m2[k]  <= {r3_mbb[k], r3_maa[k]}
                           + {{(W-1){1'b0}}, r3_mab[k], {(W+1){1'b0}}};
                r4_neg[k] <= r3_neg[k];
            end
        end
    end

    // Stage 5: partial products of l2^3
    logic [2*DW-1:0] r5_pp [4][2];
    logic            r5_zero;
    logic [M2W-1:0]  r5_m2  [3];
    logic            r5_neg [3];

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r5_pp[i][j] <= r4_l2sq[i*DW +: DW] * r4_l2[j*DW +: DW];
                end
            end
            r5_zero <= r4_zero;
            for (int k = 0; k < 3; k++) begin
                r5_m2[k]  <= r4_m2[k];
                r5_neg[k] <= r4_neg[k];
            end
        end
    end

    // Stage 6: l2^3 and the start of the quotient search
    logic [L3W-1:0] l3_sum;
    logic [L3W-1:0] r_bl3   [W+1];
    logic [NW-1:0]  r_brem  [W+1][3];
    logic [NW-1:0]  r_bprd  [W+1][3];
    logic [W-1:0]   r_bq    [W+1][3];
    logic           r_bneg  [W+1][3];
    logic           r_bzero [W+1];

    // Pack non-overlapping partial products side by side, leaving four terms to add
    always_comb begin
        l3_sum = L3W'({r5_pp[2][0], r5_pp[0][0]})
               + (L3W'({r5_pp[3][0], r5_pp[1][0]}) << DW)
               + (L3W'({r5_pp[2][1], r5_pp[0][1]}) << DW)
               + (L3W'({r5_pp[3][1], r5_pp[1][1]}) << (2 * DW));
    end

    always_ff @(posedge i_clk) begin
        if (adv[BIT0]) begin
            r_bl3[0]   <= l3_sum;
            r_bzero[0] <= r5_zero;
            for (int k = 0; k < 3; k++) begin
                r_brem[0][k] <= NW'(r5_m2[k]) << (4 * FRAC_BITS);
                r_bprd[0][k] <= '0;
                r_bq[0][k]   <= '0;
                r_bneg[0][k] <= r5_neg[k];
            end
        end
    end

    // Quotient stages: decide one bit, largest q with q^2 * l3 <= n^2.
    // Keep rem = n^2 - q^2*l3 and prd = q*l3 so each bit is one add and compare.
    for (genvar j = 0; j < W; j++) begin : g_bit
        localparam int B = W - 1 - j;
        logic [TW-1:0] trial [3];
        logic [TW-1:0] grow  [3];
        logic          take  [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                trial[k] = (TW'(r_bprd[j][k]) << (B + 1)) + (TW'(r_bl3[j]) << (2 * B));
                take[k]  = (trial[k] <= TW'(r_brem[j][k]));
                grow[k]  = TW'(r_bprd[j][k]) + (TW'(r_bl3[j]) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[BIT0+1+j]) begin
                r_bl3[j+1]   <= r_bl3[j];
                r_bzero[j+1] <= r_bzero[j];
                for (int k = 0; k < 3; k++) begin
                    r_bneg[j+1][k] <= r_bneg[j][k];
                    if (take[k]) begin
                        r_bq[j+1][k]   <= r_bq[j][k] | (W'(1) << B);
                        r_bprd[j+1][k] <= grow[k][NW-1:0];
                        r_brem[j+1][k] <= r_brem[j][k] - trial[k][NW-1:0];
                    end else begin
                        r_bq[j+1][k]   <= r_bq[j][k];
                        r_bprd[j+1][k] <= r_bprd[j][k];
                        r_brem[j+1][k] <= r_brem[j][k];
                    end
                end
            end
        end
    end

    // Output stage: apply sign, clip to range, force zero on coincident points
    localparam logic [W-1:0] MIN_MAG = W'(1) << (W - 1);
    localparam logic [W-1:0] MAX_POS = MIN_MAG - 1'b1;

    logic [W-1:0] acc   [3];
    logic         clip  [3];
    logic [W-1:0] r_acc [3];
    logic         r_sat;
    logic         r_coin;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            clip[k] = 1'b0;
            if (r_bzero[W]) begin
                acc[k] = '0;
            end else if (r_bneg[W][k]) begin
                if (r_bq[W][k] > MIN_MAG) begin
                    clip[k] = 1'b1;
                    acc[k]  = MIN_MAG;
                end else begin
                    acc[k] = ~r_bq[W][k] + 1'b1;
                end
            end else if (r_bq[W][k] > MAX_POS) begin
                clip[k] = 1'b1;
                acc[k]  = MAX_POS;
            end else begin
                acc[k] = r_bq[W][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= acc[k];
            end
            r_sat  <= clip[0] || clip[1] || clip[2];
            r_coin <= r_bzero[W];
        end
    end

    assign o_valid      = r_vld[NS-1];
    assign o_accel_x    = r_acc[0];
    assign o_accel_y    = r_acc[1];
    assign o_accel_z    = r_acc[2];
    assign o_saturated  = r_sat;
    assign o_coincident = r_coin;

endmodule

// File: rtl/pga_checker.sv
module pga_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input pga_pkg::t_coord                 o_accel_x,
    input pga_pkg::t_coord                 o_accel_y,
    input pga_pkg::t_coord                 o_accel_z,
    input logic                            o_saturated,
    input logic                            o_coincident
);
    import pga_pkg::*;

    localparam logic [COORD_WIDTH-1:0] MIN_V = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
    localparam logic [COORD_WIDTH-1:0] MAX_V = MIN_V - 1'b1;

    // Coincident points give a zero vector and no clip
    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coincident) |->
            (o_accel_x == '0 && o_accel_y == '0 && o_accel_z == '0 && !o_saturated))
        else $error("coincident item with nonzero result");

    // A clip leaves at least one component at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_accel_x == MAX_V || o_accel_x == MIN_V ||
             o_accel_y == MAX_V || o_accel_y == MIN_V ||
             o_accel_z == MAX_V || o_accel_z == MIN_V))
        else $error("saturated flag without a clipped component");

    // An empty or draining output stage lets the input through
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side can move");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_accel_x) && $stable(o_accel_y) && $stable(o_accel_z)))
        else $error("stalled result changed");

endmodule

bind pairwise_gravity_accel pga_checker u_pga_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_accel_x    (o_accel_x),
    .o_accel_y    (o_accel_y),
    .o_accel_z    (o_accel_z),
    .o_saturated  (o_saturated),
    .o_coincident (o_coincident)
);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import pga_pkg::*;

    localparam int BW        = 300;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM  = 1900;
    localparam int N_CALM    = 200;

    // Magnitude limits of the signed output range, at quotient width
    localparam logic [COORD_WIDTH:0] Q_MIN_MAG = (COORD_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
    localparam logic [COORD_WIDTH:0] Q_MAX_POS = Q_MIN_MAG - 1'b1;

    typedef struct packed {
        t_coord                 tx, ty, tz;
        t_coord                 sx, sy, sz;
        logic [COORD_WIDTH-1:0] mass;
    } t_body_pair;

    typedef struct packed {
        t_coord ax, ay, az;
        logic   sat;
        logic   coin;
    } t_accel;

    // Scoreboard: predicts the acceleration of each accepted pair and checks results
    class accel_scoreboard;
        t_accel expected_q[$];
        int     errors;
        int     n_checked;
        int     n_sat;
        int     n_coin;

        function new();
            errors    = 0;
            n_checked = 0;
            n_sat     = 0;
            n_coin    = 0;
        endfunction

        // Exact magnitude search: largest q with q^2 * l2^3 <= (m*|d|*2^2F)^2
        function automatic logic [COORD_WIDTH:0] root_quotient(logic [BW-1:0] n2,
                                                               logic [BW-1:0] l3);
            logic [BW-1:0] q;
            logic [BW-1:0] c;
            q = '0;
            for (int b = COORD_WIDTH - 1; b >= 0; b--) begin
                c = q | (BW'(1) << b);
                if (c * c * l3 <= n2) q = c;
            end
            return q[COORD_WIDTH:0];
        endfunction

        function automatic t_accel predict_accel(t_body_pair p);
            t_accel                     r;
            logic signed [COORD_WIDTH+1:0] d [3];
            logic [BW-1:0]              mag [3];
            logic [BW-1:0]              l2, l3, num, n2;
            logic [COORD_WIDTH:0]       q;
            t_coord                     comp [3];
            logic                       sat;
            d[0] = $signed({p.sx[COORD_WIDTH-1], p.sx}) - $signed({p.tx[COORD_WIDTH-1], p.tx});
            d[1] = $signed({p.sy[COORD_WIDTH-1], p.sy}) - $signed({p.ty[COORD_WIDTH-1], p.ty});
            d[2] = $signed({p.sz[COORD_WIDTH-1], p.sz}) - $signed({p.tz[COORD_WIDTH-1], p.tz});
            l2 = '0;
            for (int k = 0; k < 3; k++) begin
                mag[k] = d[k] < 0 ? BW'(-d[k]) : BW'(d[k]);
                l2 = l2 + mag[k] * mag[k];
            end
            r = '0;
            // Coincident points: zero result, flag only
            if (l2 == 0) begin
                r.coin = 1'b1;
                return r;
            end
            l3  = l2 * l2 * l2;
            sat = 1'b0;
            for (int k = 0; k < 3; k++) begin
                num = BW'(p.mass) * mag[k] * (BW'(1) << (2 * FRAC_BITS));
                n2  = num * num;
                q   = root_quotient(n2, l3);
                // Clip to the signed output range
                if (d[k] < 0) begin
                    if (q > Q_MIN_MAG) begin
                        q   = Q_MIN_MAG;
                        sat = 1'b1;
                    end
                    comp[k] = -q[COORD_WIDTH-1:0];
                end else begin
                    if (q > Q_MAX_POS) begin
                        q   = Q_MAX_POS;
                        sat = 1'b1;
                    end
                    comp[k] = q[COORD_WIDTH-1:0];
                end
            end
            r.ax  = comp[0];
            r.ay  = comp[1];
            r.az  = comp[2];
            r.sat = sat;
            return r;
        endfunction

        function void note_pair(t_body_pair p);
            expected_q.push_back(predict_accel(p));
        endfunction

        function void check_accel(t_accel got);
            t_accel want;
            if (expected_q.size() == 0) begin
                $error("result with no pending item: ax=%0d ay=%0d az=%0d",
                       got.ax, got.ay, got.az);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.sat) n_sat++;
            if (want.coin) n_coin++;
            if (got.ax !== want.ax) begin
                $error("accel_x expected %0d actual %0d", want.ax, got.ax);
                errors++;
            end
            if (got.ay !== want.ay) begin
                $error("accel_y expected %0d actual %0d", want.ay, got.ay);
                errors++;
            end
            if (got.az !== want.az) begin
                $error("accel_z expected %0d actual %0d", want.az, got.az);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated expected %0b actual %0b", want.sat, got.sat);
                errors++;
            end
            if (got.coin !== want.coin) begin
                $error("coincident expected %0b actual %0b", want.coin, got.coin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    t_coord                 i_target_x, i_target_y, i_target_z;
    t_coord                 i_source_x, i_source_y, i_source_z;
    logic [COORD_WIDTH-1:0] i_source_mass;
    logic                   o_valid;
    logic                   i_ready;
    t_coord                 o_accel_x, o_accel_y, o_accel_z;
    logic                   o_saturated;
    logic                   o_coincident;

    accel_scoreboard sb;
    bit              calm;
    int              idle_cycles;
    int              n_sent;

    pairwise_gravity_accel u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_target_z    (i_target_z),
        .i_source_x    (i_source_x),
        .i_source_y    (i_source_y),
        .i_source_z    (i_source_z),
        .i_source_mass (i_source_mass),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_accel_x     (o_accel_x),
        .o_accel_y     (o_accel_y),
        .o_accel_z     (o_accel_z),
        .o_saturated   (o_saturated),
        .o_coincident  (o_coincident)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, check each accepted result
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_accel({o_accel_x, o_accel_y, o_accel_z, o_saturated, o_coincident});
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which neither side moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one pair, optionally after an idle burst, and hold it until accepted
    task automatic send_pair(t_body_pair p);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_target_x    <= p.tx;
        i_target_y    <= p.ty;
        i_target_z    <= p.tz;
        i_source_x    <= p.sx;
        i_source_y    <= p.sy;
        i_source_z    <= p.sz;
        i_source_mass <= p.mass;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pair(p);
        n_sent++;
    endtask

    function automatic t_body_pair make_pair(t_coord tx, t_coord ty, t_coord tz,
                                             t_coord sx, t_coord sy, t_coord sz,
                                             logic [COORD_WIDTH-1:0] m);
        t_body_pair p;
        p = '{tx, ty, tz, sx, sy, sz, m};
        return p;
    endfunction

    // Offset of random scale, from a few LSBs up to the full range
    function automatic t_coord rand_offset();
        int sh;
        sh = $urandom_range(0, COORD_WIDTH - 1);
        return t_coord'($signed($urandom) >>> sh);
    endfunction

    function automatic t_body_pair rand_pair();
        t_body_pair p;
        int         mode;
        mode = $urandom_range(0, 9);
        p.tx = $urandom;
        p.ty = $urandom;
        p.tz = $urandom;
        // Mostly nearby sources, where results are not all zero or clipped
        if (mode < 6) begin
            p.sx = p.tx + rand_offset();
            p.sy = p.ty + rand_offset();
            p.sz = p.tz + rand_offset();
        end else if (mode == 6) begin
            p.sx = p.tx;
            p.sy = p.ty;
            p.sz = p.tz;
            if ($urandom_range(0, 1)) p.sx = p.tx + t_coord'($urandom_range(0, 2)) - 1;
        end else begin
            p.sx = $urandom;
            p.sy = $urandom;
            p.sz = $urandom;
        end
        case ($urandom_range(0, 3))
            0: p.mass = $urandom;
            1: p.mass = $urandom >> $urandom_range(0, 31);
            2: p.mass = $urandom_range(0, 1) ? '0 : '1;
            default: p.mass = $urandom_range(0, 1 << 20);
        endcase
        return p;
    endfunction

    localparam t_coord MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord ONE  = t_coord'(1) <<< FRAC_BITS;

    initial begin
        sb          = new();
        calm        = 1'b0;
        n_sent      = 0;
        idle_cycles = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_target_x    = '0;
        i_target_y    = '0;
        i_target_z    = '0;
        i_source_x    = '0;
        i_source_y    = '0;
        i_source_z    = '0;
        i_source_mass = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coincident, zero mass, unit distance, extremes, clipping
        send_pair(make_pair('0, '0, '0, '0, '0, '0, '0));
        send_pair(make_pair(ONE, ONE, ONE, ONE, ONE, ONE, '1));
        send_pair(make_pair(MINC, MAXC, '0, MINC, MAXC, '0, ONE));
        send_pair(make_pair('0, '0, '0, ONE, '0, '0, ONE));
        send_pair(make_pair('0, '0, '0, -ONE, '0, '0, ONE));
        send_pair(make_pair('0, '0, '0, '0, ONE, '0, '0));
        send_pair(make_pair('0, '0, '0, '0, '0, -ONE, '1));
        send_pair(make_pair('0, '0, '0, 1, '0, '0, 1));
        send_pair(make_pair('0, '0, '0, -1, '0, '0, '1));
        send_pair(make_pair(MAXC, '0, '0, MINC, '0, '0, '1));
        send_pair(make_pair(MINC, '0, '0, MAXC, '0, '0, '1));
        send_pair(make_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, '1));
        send_pair(make_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC, '1));
        send_pair(make_pair(MAXC, MINC, MAXC, MINC, MAXC, MINC, 1));
        send_pair(make_pair('0, '0, '0, ONE, ONE, ONE, ONE));
        send_pair(make_pair('0, '0, '0, 1, -1, 1, ONE));
        send_pair(make_pair(ONE, -ONE, '0, -ONE, ONE, 1, {1'b1, {(COORD_WIDTH-1){1'b0}}}));
        send_pair(make_pair('1, '1, '1, '0, '0, '0, '1));
        send_pair(make_pair('0, '0, '0, MAXC, '0, '0, 1));
        send_pair(make_pair('0, '0, '0, ONE <<< 4, ONE <<< 3, -(ONE <<< 2), ONE <<< 8));

        // Random pairs; one pause to drain the pipeline partway through
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (i == N_RANDOM - N_CALM) calm = 1'b1;
            send_pair(rand_pair());
        end
        i_valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (COORD_WIDTH + 20) @(posedge i_clk);

        $display("sent %0d pairs, checked %0d results", n_sent, sb.n_checked);
        $display("clipped results %0d, coincident results %0d", sb.n_sat, sb.n_coin);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
